FILE: hdl/mhs_pkg.sv
// Package for the min-hash slot sampler.
// Holds the hash constants, outcome codes, slot entry layout and the
// controller/datapath command types. Depends on nothing.
package mhs_pkg;

    // Hash constants: one offset and two multipliers.
    localparam logic [63:0] MIX_ADD = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] MIX_MUL1 = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_MUL2 = 64'h94d0_49bb_1331_11eb;

    // Shift amounts of the three xor-shift rounds.
    localparam int unsigned SHIFT_A = 30;
    localparam int unsigned SHIFT_B = 27;
    localparam int unsigned SHIFT_C = 31;

    // Width of the reported slot index.
    localparam int unsigned SLOT_INDEX_W = 12;

    // Outcome codes.
    localparam logic [1:0] OUT_INSERTED = 2'd0;
    localparam logic [1:0] OUT_BLOCKED = 2'd1;
    localparam logic [1:0] OUT_UPDATED = 2'd2;
    localparam logic [1:0] OUT_REPLACED = 2'd3;

    // One slot entry as held in the table memory.
    typedef struct packed {
        logic        vld;
        logic [63:0] key;
        logic [63:0] hash;
        logic [63:0] stamp;
    } t_entry;

    // Controller states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_XS_A,
        S_M1_LL,
        S_M1_LH,
        S_M1_HL,
        S_XS_B,
        S_M2_LL,
        S_M2_LH,
        S_M2_HL,
        S_XS_C,
        S_READ,
        S_DECIDE
    } t_state;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_XS_A,
        OP_XS_B,
        OP_XS_C,
        OP_MUL_LL,
        OP_MUL_LH,
        OP_MUL_HL,
        OP_READ,
        OP_DECIDE
    } t_op;

    // Command from controller to datapath.
    typedef struct packed {
        t_op  op;
        logic mul_sel2;  // selects the second multiplier constant
    } t_dp_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic clr_last;
    } t_dp_stat;

endpackage

FILE: hdl/mhs_in_if.sv
// Input channel of the min-hash slot sampler: one item is a key and a timestamp.
// Depends on nothing.
interface mhs_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] item_key;
    logic [63:0] item_time;

    modport source (output valid, output item_key, output item_time, input ready);
    modport sink (input valid, input item_key, input item_time, output ready);
endinterface

FILE: hdl/mhs_out_if.sv
// Result channel of the min-hash slot sampler: outcome code and slot index.
// Depends on nothing.
interface mhs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  outcome;
    logic [11:0] slot_index;

    modport source (output valid, output outcome, output slot_index, input ready);
    modport sink (input valid, input outcome, input slot_index, output ready);
endinterface

FILE: hdl/mhs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mhs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/mhs_ctrl.sv
// Controller of the min-hash slot sampler: sequences clearing, hashing,
// table lookup and result hand-off. Depends on mhs_pkg.
module mhs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mhs_pkg::t_dp_cmd  o_cmd,
    input  mhs_pkg::t_dp_stat i_stat
);

    mhs_pkg::t_state r_state;
    mhs_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            out_free;

    // The result register can take a new result when empty or being drained.
    assign out_free = !r_out_valid || i_out_ready;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mhs_pkg::S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = mhs_pkg::S_IDLE;
                end
            end
            mhs_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = mhs_pkg::S_XS_A;
                end
            end
            mhs_pkg::S_XS_A:   n_state = mhs_pkg::S_M1_LL;
            mhs_pkg::S_M1_LL:  n_state = mhs_pkg::S_M1_LH;
            mhs_pkg::S_M1_LH:  n_state = mhs_pkg::S_M1_HL;
            mhs_pkg::S_M1_HL:  n_state = mhs_pkg::S_XS_B;
            mhs_pkg::S_XS_B:   n_state = mhs_pkg::S_M2_LL;
            mhs_pkg::S_M2_LL:  n_state = mhs_pkg::S_M2_LH;
            mhs_pkg::S_M2_LH:  n_state = mhs_pkg::S_M2_HL;
            mhs_pkg::S_M2_HL:  n_state = mhs_pkg::S_XS_C;
            mhs_pkg::S_XS_C:   n_state = mhs_pkg::S_READ;
            mhs_pkg::S_READ:   n_state = mhs_pkg::S_DECIDE;
            mhs_pkg::S_DECIDE: begin
                if (out_free) begin
                    n_state = mhs_pkg::S_IDLE;
                end
            end
            default:           n_state = mhs_pkg::S_CLEAR;
        endcase
    end

    // Output logic: datapath command and input handshake.
    always_comb begin
        o_cmd.op = mhs_pkg::OP_NONE;
        o_cmd.mul_sel2 = 1'b0;
        o_in_ready = 1'b0;
        unique case (r_state)
            mhs_pkg::S_CLEAR: o_cmd.op = mhs_pkg::OP_CLEAR;
            mhs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = mhs_pkg::OP_LOAD;
                end
            end
            mhs_pkg::S_XS_A:  o_cmd.op = mhs_pkg::OP_XS_A;
            mhs_pkg::S_M1_LL: o_cmd.op = mhs_pkg::OP_MUL_LL;
            mhs_pkg::S_M1_LH: o_cmd.op = mhs_pkg::OP_MUL_LH;
            mhs_pkg::S_M1_HL: o_cmd.op = mhs_pkg::OP_MUL_HL;
            mhs_pkg::S_XS_B:  o_cmd.op = mhs_pkg::OP_XS_B;
            mhs_pkg::S_M2_LL: begin
                o_cmd.op = mhs_pkg::OP_MUL_LL;
                o_cmd.mul_sel2 = 1'b1;
            end
            mhs_pkg::S_M2_LH: begin
                o_cmd.op = mhs_pkg::OP_MUL_LH;
                o_cmd.mul_sel2 = 1'b1;
            end
            mhs_pkg::S_M2_HL: begin
                o_cmd.op = mhs_pkg::OP_MUL_HL;
                o_cmd.mul_sel2 = 1'b1;
            end
            mhs_pkg::S_XS_C:  o_cmd.op = mhs_pkg::OP_XS_C;
            mhs_pkg::S_READ:  o_cmd.op = mhs_pkg::OP_READ;
            mhs_pkg::S_DECIDE: begin
                if (out_free) begin
                    o_cmd.op = mhs_pkg::OP_DECIDE;
                end
            end
            default:          o_cmd.op = mhs_pkg::OP_NONE;
        endcase
    end

    // Result valid flag: set when a decision is stored, cleared when taken.
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (o_cmd.op == mhs_pkg::OP_DECIDE) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mhs_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: hdl/mhs_dp.sv
// Datapath of the min-hash slot sampler: shared 32x32 multiplier for the hash,
// slot table memory, decision logic and result register.
// Depends on mhs_pkg and mhs_ram.
module mhs_dp #(
    parameter int unsigned SLOTS = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mhs_pkg::t_dp_cmd                 i_cmd,
    output mhs_pkg::t_dp_stat                o_stat,
    input  logic [63:0]                      i_item_key,
    input  logic [63:0]                      i_item_time,
    output logic [1:0]                       o_outcome,
    output logic [mhs_pkg::SLOT_INDEX_W-1:0] o_slot_index
);

    localparam int unsigned AW = $clog2(SLOTS);
    localparam int unsigned EW = $bits(mhs_pkg::t_entry);

    logic [63:0]  r_key;
    logic [63:0]  r_stamp;
    logic [63:0]  r_z;
    logic [63:0]  r_acc;
    logic [AW-1:0] r_clr_addr;
    logic [1:0]   r_outcome;
    logic [mhs_pkg::SLOT_INDEX_W-1:0] r_slot_index;

    logic [63:0]  mul_const;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [63:0]  prod;
    logic [AW-1:0] idx;

    mhs_pkg::t_entry rd_entry;
    mhs_pkg::t_entry upd_entry;
    logic [EW-1:0] rd_bits;
    logic [EW-1:0] ram_wdata;
    logic [AW-1:0] ram_waddr;
    logic          ram_we;
    logic          upd_we;
    logic [1:0]    upd_outcome;

    // Slot number from the low hash bits.
    assign idx = r_z[AW-1:0];

    // Operand selection for the shared multiplier: one 32x32 partial product
    // per step, keeping the low 64 bits of the full product.
    assign mul_const = i_cmd.mul_sel2 ? mhs_pkg::MIX_MUL2 : mhs_pkg::MIX_MUL1;

    always_comb begin
        mul_a = r_z[31:0];
        mul_b = mul_const[31:0];
        case (i_cmd.op)
            mhs_pkg::OP_MUL_LH: mul_b = mul_const[63:32];
            mhs_pkg::OP_MUL_HL: mul_a = r_z[63:32];
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    // Hash and item registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            mhs_pkg::OP_LOAD: begin
                r_key <= i_item_key;
                r_stamp <= i_item_time;
                r_z <= i_item_key + mhs_pkg::MIX_ADD;
            end
            mhs_pkg::OP_XS_A: r_z <= r_z ^ (r_z >> mhs_pkg::SHIFT_A);
            mhs_pkg::OP_XS_B: r_z <= r_z ^ (r_z >> mhs_pkg::SHIFT_B);
            mhs_pkg::OP_XS_C: r_z <= r_z ^ (r_z >> mhs_pkg::SHIFT_C);
            mhs_pkg::OP_MUL_LL: r_acc <= prod;
            mhs_pkg::OP_MUL_LH: r_acc <= r_acc + {prod[31:0], 32'h0};
            mhs_pkg::OP_MUL_HL: r_z <= r_acc + {prod[31:0], 32'h0};
            default: ;
        endcase
    end

    // Clearing pass address counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.op == mhs_pkg::OP_CLEAR) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_stat.clr_last = (r_clr_addr == AW'(SLOTS - 1));

    // Decision on the incumbent entry read from the table.
    assign rd_entry = mhs_pkg::t_entry'(rd_bits);

    always_comb begin
        upd_entry = rd_entry;
        upd_we = 1'b0;
        upd_outcome = mhs_pkg::OUT_BLOCKED;
        if (!rd_entry.vld) begin
            upd_entry = '{vld: 1'b1, key: r_key, hash: r_z, stamp: r_stamp};
            upd_we = 1'b1;
            upd_outcome = mhs_pkg::OUT_INSERTED;
        end else if (rd_entry.key == r_key) begin
            if (rd_entry.stamp > r_stamp) begin
                upd_entry.stamp = r_stamp;
                upd_we = 1'b1;
                upd_outcome = mhs_pkg::OUT_UPDATED;
            end
        end else if (rd_entry.hash > r_z) begin
            upd_entry = '{vld: 1'b1, key: r_key, hash: r_z, stamp: r_stamp};
            upd_we = 1'b1;
            upd_outcome = mhs_pkg::OUT_REPLACED;
        end
    end

    // Table write port: clearing pass or decision write-back.
    always_comb begin
        ram_we = 1'b0;
        ram_waddr = idx;
        ram_wdata = EW'(upd_entry);
        if (i_cmd.op == mhs_pkg::OP_CLEAR) begin
            ram_we = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (i_cmd.op == mhs_pkg::OP_DECIDE) begin
            ram_we = upd_we;
        end
    end

    mhs_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.op == mhs_pkg::OP_READ),
        .i_raddr (idx),
        .o_rdata (rd_bits)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == mhs_pkg::OP_DECIDE) begin
            r_outcome <= upd_outcome;
            r_slot_index <= mhs_pkg::SLOT_INDEX_W'(idx);
        end
    end

    assign o_outcome = r_outcome;
    assign o_slot_index = r_slot_index;

endmodule

FILE: hdl/min_hash_slot_sampler.sv
// Top level of the min-hash slot sampler: joins controller and datapath.
// Depends on mhs_pkg, mhs_in_if, mhs_out_if, mhs_ctrl and mhs_dp.
//
// Usage:
// - i_in (sink) takes one item: a 64-bit key and a 64-bit timestamp.
// - o_out (source) gives one result per item: a 2-bit outcome (inserted,
//   blocked, updated or replaced) and the low 12 bits of the chosen slot.
// - After reset a clearing pass writes every slot empty, one slot a cycle;
//   i_in.ready stays low during the pass.
// - An item is hashed on one shared 32x32 multiplier: two 64-bit products of
//   three partial products each, plus the xor-shift rounds. Then the slot is
//   read from the table memory (registered read) and, unless blocked, written back.
// - An item runs through the states XS_A, M1_LL, M1_LH, M1_HL, XS_B, M2_LL,
//   M2_LH, M2_HL, XS_C, READ and DECIDE; the result is registered on o_out
//   and a new item is taken only once that state sequence is through.
// - The result sits in an output register, so the next item is accepted
//   and hashed while a result waits. If the receiver still stalls when the
//   next decision is due, the block holds that item until o_out drains.
module min_hash_slot_sampler #(
    parameter int unsigned SLOTS = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mhs_in_if.sink    i_in,
    mhs_out_if.source o_out
);

    mhs_pkg::t_dp_cmd  cmd;
    mhs_pkg::t_dp_stat stat;

    mhs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    mhs_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_item_key   (i_in.item_key),
        .i_item_time  (i_in.item_time),
        .o_outcome    (o_out.outcome),
        .o_slot_index (o_out.slot_index)
    );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Testbench for min_hash_slot_sampler: directed and random items are checked against
// an in-bench model of the key hash and the slot table.
// Depends on mhs_pkg, mhs_in_if, mhs_out_if and the block under test.
module tb;

    localparam int unsigned SLOTS = 4096;
    localparam int unsigned SLOT_BITS = 12;
    localparam int unsigned HOT_SETS = 32;
    localparam int unsigned SET_KEYS = 6;
    localparam int unsigned LONG_STALL_CYCLES = 400;
    localparam int unsigned STALL_ITEMS = 40;
    localparam int unsigned RANDOM_ITEMS = 1750;
    localparam int unsigned DRAIN_CYCLES = 30;
    localparam int unsigned DRAIN_LIMIT = 20000;

    // Finaliser constants of the 64-bit key hash.
    localparam bit [63:0] HASH_GAMMA = 64'h9e37_79b9_7f4a_7c15;
    localparam bit [63:0] HASH_MUL_A = 64'hbf58_476d_1ce4_e5b9;
    localparam bit [63:0] HASH_MUL_B = 64'h94d0_49bb_1331_11eb;

    // One expected result: outcome code and reported slot.
    typedef struct {
        logic [1:0]  outcome;
        logic [11:0] slot;
    } t_slot_report;

    logic i_clk;
    logic i_rst_n;

    mhs_in_if  item_if ();
    mhs_out_if result_if ();

    min_hash_slot_sampler #(
        .SLOTS(SLOTS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (item_if),
        .o_out  (result_if)
    );

    // Model of the slot table.
    bit        table_full  [SLOTS];
    bit [63:0] table_key   [SLOTS];
    bit [63:0] table_hash  [SLOTS];
    bit [63:0] table_stamp [SLOTS];

    // Reports still owed by the block, oldest first.
    t_slot_report pending_reports [$];

    // Keys grouped so that every key of a set lands in the same slot.
    bit [63:0]   set_key  [HOT_SETS][SET_KEYS];

    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned outcome_seen [4];

    bit   src_gaps_on;
    bit   sink_gaps_on;
    bit   sink_frozen;
    event long_stall_start;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit on the length of the run.
    initial begin : watchdog
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bit [63:0] key_hash(input bit [63:0] key);
        bit [63:0] z;
        z = key + HASH_GAMMA;
        z = (z ^ (z >> 30)) * HASH_MUL_A;
        z = (z ^ (z >> 27)) * HASH_MUL_B;
        return z ^ (z >> 31);
    endfunction

    function automatic int unsigned slot_of(input bit [63:0] key);
        bit [63:0] h;
        h = key_hash(key);
        return h[SLOT_BITS-1:0];
    endfunction

    // Applies one accepted item to the table model and queues its report.
    function automatic void predict_slot_update(input bit [63:0] key, input bit [63:0] stamp);
        bit [63:0]    h;
        int unsigned  s;
        t_slot_report r;
        h = key_hash(key);
        s = h[SLOT_BITS-1:0];
        r.slot = s[11:0];
        if (!table_full[s]) begin
            table_full[s] = 1'b1;
            table_key[s] = key;
            table_hash[s] = h;
            table_stamp[s] = stamp;
            r.outcome = mhs_pkg::OUT_INSERTED;
        end else if (table_key[s] == key) begin
            // Same key: only a strictly earlier stamp takes the entry.
            if (table_stamp[s] > stamp) begin
                table_stamp[s] = stamp;
                r.outcome = mhs_pkg::OUT_UPDATED;
            end else begin
                r.outcome = mhs_pkg::OUT_BLOCKED;
            end
        end else if (table_hash[s] > h) begin
            table_key[s] = key;
            table_hash[s] = h;
            table_stamp[s] = stamp;
            r.outcome = mhs_pkg::OUT_REPLACED;
        end else begin
            r.outcome = mhs_pkg::OUT_BLOCKED;
        end
        pending_reports.push_back(r);
    endfunction

    // Searches random keys until every set holds enough keys for its slot.
    task automatic build_contention_sets();
        int          set_of_slot [SLOTS];
        int unsigned fill [HOT_SETS];
        int unsigned missing;
        int unsigned s;
        bit [63:0]   cand;
        foreach (set_of_slot[i]) set_of_slot[i] = -1;
        for (int i = 0; i < HOT_SETS; i++) begin
            // The first two sets sit on the lowest and the highest slot.
            if (i == 0) begin
                s = 0;
            end else if (i == 1) begin
                s = SLOTS - 1;
            end else begin
                do s = $urandom_range(1, SLOTS - 2); while (set_of_slot[s] != -1);
            end
            set_of_slot[s] = i;
            fill[i] = 0;
        end
        missing = HOT_SETS * SET_KEYS;
        while (missing != 0) begin
            cand = rand64();
            s = slot_of(cand);
            if (set_of_slot[s] >= 0 && fill[set_of_slot[s]] < SET_KEYS) begin
                set_key[set_of_slot[s]][fill[set_of_slot[s]]] = cand;
                fill[set_of_slot[s]]++;
                missing--;
            end
        end
    endtask

    // Offers one item, after a random gap when source gaps are on, and returns once it is accepted.
    task automatic offer_item(input bit [63:0] key, input bit [63:0] stamp);
        int unsigned gap;
        gap = src_gaps_on ? $urandom_range(0, 17) : 0;
        if (gap != 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.item_key <= key;
        item_if.item_time <= stamp;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        predict_slot_update(key, stamp);
        items_sent++;
    endtask

    // Compares one accepted result with the oldest outstanding report.
    function automatic void check_report(input logic [1:0] outcome, input logic [11:0] slot);
        t_slot_report r;
        if (pending_reports.size() == 0) begin
            $display("%0t: result with no item outstanding, expected none, got outcome %0d slot %0d",
                     $time, outcome, slot);
            mismatches++;
            return;
        end
        r = pending_reports.pop_front();
        if (outcome !== r.outcome) begin
            $display("%0t: outcome mismatch, expected %0d, got %0d", $time, r.outcome, outcome);
            mismatches++;
        end
        if (slot !== r.slot) begin
            $display("%0t: slot_index mismatch, expected %0d, got %0d", $time, r.slot, slot);
            mismatches++;
        end
        outcome_seen[r.outcome]++;
    endfunction

    // Result side: checks every accepted item and stalls at random in between.
    initial begin : result_sink
        int unsigned idle_left;
        idle_left = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
                check_report(result_if.outcome, result_if.slot_index);
                idle_left = sink_gaps_on ? $urandom_range(0, 17) : 0;
            end else if (idle_left != 0) begin
                idle_left--;
            end
            result_if.ready <= (idle_left == 0) && !sink_frozen;
        end
    end

    // Long receiver hold-off, counted here so the sender keeps offering items.
    initial begin : long_stall
        sink_frozen <= 1'b0;
        forever begin
            @(long_stall_start);
            sink_frozen <= 1'b1;
            repeat (LONG_STALL_CYCLES) @(posedge i_clk);
            sink_frozen <= 1'b0;
        end
    end

    // Zero and all-ones keys and stamps, including equal stamps on one key.
    task automatic test_key_extremes();
        src_gaps_on = 1'b0;
        sink_gaps_on <= 1'b0;
        offer_item(64'd0, 64'd5);
        offer_item(64'd0, 64'd9);
        offer_item(64'd0, 64'd5);
        offer_item(64'd0, 64'd2);
        offer_item('1, '1);
        offer_item('1, 64'd0);
        offer_item('1, 64'd0);
        offer_item(64'd0, '1);
    endtask

    // Several keys fight over the lowest and the highest slot.
    task automatic test_slot_contention();
        src_gaps_on = 1'b1;
        sink_gaps_on <= 1'b1;
        for (int i = 0; i < 2; i++) begin
            for (int k = 0; k < SET_KEYS; k++) offer_item(set_key[i][k], rand64());
            offer_item(set_key[i][0], 64'd0);
        end
    endtask

    // Holds the result side off long enough that the block stops taking items.
    task automatic test_output_backpressure();
        src_gaps_on = 1'b0;
        sink_gaps_on <= 1'b0;
        -> long_stall_start;
        for (int n = 0; n < STALL_ITEMS; n++) begin
            offer_item(set_key[$urandom_range(2, HOT_SETS - 1)][$urandom_range(0, SET_KEYS - 1)],
                       rand64());
        end
    endtask

    // Mostly contended keys, some repeats of the previous key, some fresh keys.
    task automatic test_random_traffic();
        bit [63:0]   key;
        bit [63:0]   stamp;
        bit [63:0]   last_key;
        int unsigned pick;
        int unsigned s;
        last_key = rand64();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                src_gaps_on = ($urandom_range(0, 3) != 0);
                sink_gaps_on <= ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                key = set_key[$urandom_range(2, HOT_SETS - 1)][$urandom_range(0, SET_KEYS - 1)];
            end else if (pick < 80) begin
                key = last_key;
            end else begin
                key = rand64();
            end
            // Now and then reuse the stamp held in the slot to hit equal stamps.
            s = slot_of(key);
            if (table_full[s] && $urandom_range(0, 19) == 0) begin
                stamp = table_stamp[s];
            end else begin
                stamp = rand64();
            end
            offer_item(key, stamp);
            last_key = key;
        end
    endtask

    // Reset, tests in turn, drain and verdict.
    initial begin : stimulus
        int unsigned waited;
        i_rst_n <= 1'b0;
        item_if.valid <= 1'b0;
        item_if.item_key <= '0;
        item_if.item_time <= '0;
        src_gaps_on = 1'b0;
        sink_gaps_on <= 1'b0;
        build_contention_sets();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_key_extremes();
        test_slot_contention();
        test_output_backpressure();
        test_random_traffic();
        item_if.valid <= 1'b0;

        waited = 0;
        while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d items over %0d contended slot sets and random keys.",
                 items_sent, HOT_SETS);
        $display("Results seen: %0d inserted, %0d blocked, %0d updated, %0d replaced.",
                 outcome_seen[mhs_pkg::OUT_INSERTED], outcome_seen[mhs_pkg::OUT_BLOCKED],
                 outcome_seen[mhs_pkg::OUT_UPDATED], outcome_seen[mhs_pkg::OUT_REPLACED]);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (pending_reports.size() != 0)
                $display("%0t: %0d results never arrived", $time, pending_reports.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/mhs_pkg.sv
hdl/mhs_in_if.sv
hdl/mhs_out_if.sv
hdl/mhs_ram.sv
hdl/mhs_ctrl.sv
hdl/mhs_dp.sv
hdl/min_hash_slot_sampler.sv
dv/tb.sv
